/* rtl/core/reb_pkg.sv */
// Shared types, constants and helper functions of the rotary encoder block.
package reb_pkg;

  localparam int TIMER_BITS = 24;
  localparam int STEP_BITS  = 32;
  localparam int CMP_BITS   = 32;
  localparam int LOCK_BITS  = 16;
  localparam int CFG_BITS   = 24;
  localparam int LEN_BITS   = 24;
  localparam int TOTAL_BITS = 32;
  localparam int IDX_BITS   = 2;
  localparam int IN_BYTES_BITS  = 8;
  localparam int OUT_BYTES_BITS = 64;

  localparam logic [LOCK_BITS-1:0] LOCKOUT_RST  = LOCK_BITS'(1500);
  localparam logic [CFG_BITS-1:0]  DEBOUNCE_RST = CFG_BITS'(50000);
  localparam logic [CFG_BITS-1:0]  LONG_RST     = CFG_BITS'(1000000);
  localparam logic [LEN_BITS-1:0]  LEN_MAX      = '1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_LOCKOUT  = 2'd0,
    REG_DEBOUNCE = 2'd1,
    REG_LONG     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'b00,
    STEP_CW   = 2'b01,
    STEP_CCW  = 2'b11
  } step_code_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_GHOST = 2'd3
  } press_ev_t;

  typedef struct packed {
    logic a;
    logic b;
    logic sw;
  } sample_t;

  typedef struct packed {
    logic [1:0]            step;
    logic [TOTAL_BITS-1:0] total;
  } rot_res_t;

  typedef struct packed {
    logic [1:0]          event_code;
    logic [LEN_BITS-1:0] length;
  } press_res_t;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (&v) ? v : v + TIMER_BITS'(1);
  endfunction

  // Gray-code transition table, index {prev, cur}
  function automatic step_code_t quad_step(input logic [1:0] prev, input logic [1:0] cur);
    logic [3:0] idx;
    idx = {prev, cur};
    unique case (idx)
      4'd2, 4'd4, 4'd11, 4'd13: quad_step = STEP_CW;
      4'd1, 4'd7, 4'd8, 4'd14:  quad_step = STEP_CCW;
      default:                  quad_step = STEP_NONE;
    endcase
  endfunction

endpackage

/* rtl/core/rotary_encoder_with_button.sv */
// Rotary encoder with push button: top level with sample and result registers.
// A request accepted into the sample register moves on to the result register once
//   that register is free. Throughput: one request per cycle while out_tready is
//   high; a stalled output holds at most two requests, one in each register.
// Reset (rst_n, synchronous, active low) clears both stages, restores the
//   register defaults and returns decoder and switch state to idle.
module rotary_encoder_with_button (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [0] line_a, [1] line_b, [2] switch_level, [7:3] zero
  input  logic [reb_pkg::IN_BYTES_BITS-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] rotation_step, [33:2] step_total, [35:34] press_event,
  // [59:36] press_length, [63:60] zero
  output logic [reb_pkg::OUT_BYTES_BITS-1:0]    out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [reb_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [reb_pkg::CFG_BITS-1:0]          cfg_wdata
);

  logic [reb_pkg::LOCK_BITS-1:0] lockout_r;
  logic [reb_pkg::CFG_BITS-1:0]  debounce_r;
  logic [reb_pkg::CFG_BITS-1:0]  long_r;

  logic                s1_valid_r, s1_valid_nxt;
  reb_pkg::sample_t    s1_smp_r;
  logic                out_valid_r, out_valid_nxt;
  reb_pkg::rot_res_t   rot_res;
  reb_pkg::press_res_t prs_res;
  reb_pkg::rot_res_t   out_rot_r;
  reb_pkg::press_res_t out_prs_r;
  logic                advance, in_fire, s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r  <= reb_pkg::LOCKOUT_RST;
      debounce_r <= reb_pkg::DEBOUNCE_RST;
      long_r     <= reb_pkg::LONG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        reb_pkg::REG_LOCKOUT:  lockout_r  <= cfg_wdata[reb_pkg::LOCK_BITS-1:0];
        reb_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata;
        reb_pkg::REG_LONG:     long_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_smp_r.a  <= in_tdata[0];
      s1_smp_r.b  <= in_tdata[1];
      s1_smp_r.sw <= in_tdata[2];
    end
    if (s1_fire) begin
      out_rot_r <= rot_res;
      out_prs_r <= prs_res;
    end
  end

  reb_quad_dec u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_fire),
    .a       (s1_smp_r.a),
    .b       (s1_smp_r.b),
    .lockout (lockout_r),
    .res     (rot_res)
  );

  reb_press_det u_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_fire),
    .a        (s1_smp_r.a),
    .b        (s1_smp_r.b),
    .sw       (s1_smp_r.sw),
    .debounce (debounce_r),
    .long_thr (long_r),
    .res      (prs_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_prs_r.length, out_prs_r.event_code,
                       out_rot_r.total, out_rot_r.step};

`ifndef SYNTHESIS
  // a result without a press event carries no length
  a_len_only_with_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_prs_r.event_code == reb_pkg::EV_NONE) |-> out_prs_r.length == '0)
    else $error("press length without event");

  // a request leaving the sample stage always lands in the result register
  a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result lost between stages");
`endif

endmodule

/* rtl/core/reb_quad_dec.sv */
// Quadrature decoder with rotation lockout and wrapping step total.
module reb_quad_dec (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                a,
  input  logic                                b,
  input  logic [reb_pkg::LOCK_BITS-1:0]       lockout,
  output reb_pkg::rot_res_t                   res
);

  logic [1:0]                     prev_r, prev_nxt;
  logic [reb_pkg::TIMER_BITS-1:0] since_r, since_nxt;
  logic [reb_pkg::STEP_BITS-1:0]  cnt_r, cnt_nxt;
  logic [reb_pkg::TIMER_BITS-1:0] elapsed;
  logic                           open_win;
  reb_pkg::step_code_t            step;

  always_comb begin
    elapsed   = reb_pkg::sat_inc(since_r);
    open_win  = reb_pkg::CMP_BITS'(elapsed) >= reb_pkg::CMP_BITS'(lockout);
    step      = reb_pkg::STEP_NONE;
    prev_nxt  = prev_r;
    since_nxt = elapsed;
    cnt_nxt   = cnt_r;
    if (open_win) begin
      step     = reb_pkg::quad_step(prev_r, {a, b});
      prev_nxt = {a, b};
      if (step == reb_pkg::STEP_CW) begin
        cnt_nxt   = cnt_r + reb_pkg::STEP_BITS'(1);
        since_nxt = '0;
      end else if (step == reb_pkg::STEP_CCW) begin
        cnt_nxt   = cnt_r - reb_pkg::STEP_BITS'(1);
        since_nxt = '0;
      end
    end
    res.step  = step;
    res.total = reb_pkg::TOTAL_BITS'($signed(cnt_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 2'b11;
      since_r <= '0;
      cnt_r   <= '0;
    end else if (en) begin
      prev_r  <= prev_nxt;
      since_r <= since_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // accepted step restarts the lockout timer
  a_step_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    en && (step != reb_pkg::STEP_NONE) |=> since_r == '0)
    else $error("lockout timer not cleared after step");

  // no step while inside the lockout window
  a_lockout_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !open_win |-> step == reb_pkg::STEP_NONE && prev_nxt == prev_r)
    else $error("step taken inside lockout");
`endif

endmodule

/* rtl/core/reb_press_det.sv */
// Switch debounce and press classification.
module reb_press_det (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          a,
  input  logic                          b,
  input  logic                          sw,
  input  logic [reb_pkg::CFG_BITS-1:0]  debounce,
  input  logic [reb_pkg::CFG_BITS-1:0]  long_thr,
  output reb_pkg::press_res_t           res
);

  logic                           last_raw_r, last_raw_nxt;
  logic                           deb_r, deb_nxt;
  logic [reb_pkg::TIMER_BITS-1:0] stable_r, stable_nxt;
  logic                           busy_r, busy_nxt;
  logic [reb_pkg::TIMER_BITS-1:0] pticks_r, pticks_nxt;
  logic                           a_at_r, a_at_nxt;
  logic                           b_at_r, b_at_nxt;
  reb_pkg::press_ev_t             ev;
  logic [reb_pkg::LEN_BITS-1:0]   len;

  always_comb begin
    pticks_nxt   = busy_r ? reb_pkg::sat_inc(pticks_r) : pticks_r;
    last_raw_nxt = sw;
    stable_nxt   = (sw != last_raw_r) ? '0 : reb_pkg::sat_inc(stable_r);
    deb_nxt      = deb_r;
    busy_nxt     = busy_r;
    a_at_nxt     = a_at_r;
    b_at_nxt     = b_at_r;
    ev           = reb_pkg::EV_NONE;
    len          = '0;
    if (reb_pkg::CMP_BITS'(stable_nxt) >= reb_pkg::CMP_BITS'(debounce)) begin
      deb_nxt = sw;
      if (deb_r && !sw) begin
        busy_nxt   = 1'b1;
        pticks_nxt = '0;
        a_at_nxt   = a;
        b_at_nxt   = b;
      end else if (!deb_r && sw && busy_r) begin
        busy_nxt = 1'b0;
        len = (reb_pkg::CMP_BITS'(pticks_nxt) > reb_pkg::CMP_BITS'(reb_pkg::LEN_MAX)) ?
              reb_pkg::LEN_MAX : reb_pkg::LEN_BITS'(pticks_nxt);
        if (a != a_at_r || b != b_at_r) begin
          ev = reb_pkg::EV_GHOST;
        end else if (reb_pkg::CMP_BITS'(pticks_nxt) >= reb_pkg::CMP_BITS'(long_thr)) begin
          ev = reb_pkg::EV_LONG;
        end else begin
          ev = reb_pkg::EV_SHORT;
        end
      end
    end
    res.event_code = ev;
    res.length     = len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      deb_r      <= 1'b1;
      stable_r   <= '0;
      busy_r     <= 1'b0;
      pticks_r   <= '0;
      a_at_r     <= 1'b1;
      b_at_r     <= 1'b1;
    end else if (en) begin
      last_raw_r <= last_raw_nxt;
      deb_r      <= deb_nxt;
      stable_r   <= stable_nxt;
      busy_r     <= busy_nxt;
      pticks_r   <= pticks_nxt;
      a_at_r     <= a_at_nxt;
      b_at_r     <= b_at_nxt;
    end
  end

`ifndef SYNTHESIS
  // a reported press ends the press in progress
  a_event_ends_press: assert property (@(posedge clk) disable iff (!rst_n)
    en && (ev != reb_pkg::EV_NONE) |=> !busy_r)
    else $error("press still active after event");

  // events only come out of a press in progress
  a_event_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    (ev != reb_pkg::EV_NONE) |-> busy_r && !deb_r)
    else $error("event without press");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the rotary encoder with push button.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [1:0]                     step;
    logic [reb_pkg::TOTAL_BITS-1:0] total;
    logic [1:0]                     ev;
    logic [reb_pkg::LEN_BITS-1:0]   len;
  } knob_report_t;

  // Tracks dial and button state and holds the reports still due from the block.
  class knob_scoreboard;
    logic [reb_pkg::LOCK_BITS-1:0]  lockout  = reb_pkg::LOCKOUT_RST;
    logic [reb_pkg::CFG_BITS-1:0]   debounce = reb_pkg::DEBOUNCE_RST;
    logic [reb_pkg::CFG_BITS-1:0]   long_thr = reb_pkg::LONG_RST;

    logic [1:0]                     prev_ab      = 2'b11;
    logic [reb_pkg::TIMER_BITS-1:0] since_step   = '0;
    logic [reb_pkg::TOTAL_BITS-1:0] total        = '0;
    bit                             raw_sw       = 1'b1;
    bit                             deb_sw       = 1'b1;
    logic [reb_pkg::TIMER_BITS-1:0] stable_ticks = '0;
    bit                             pressing     = 1'b0;
    logic [reb_pkg::TIMER_BITS-1:0] held_ticks   = '0;
    logic [1:0]                     ab_at_press  = 2'b11;

    knob_report_t due_reports[$];
    int mismatch_count = 0;

    function void set_reg(reb_pkg::cfg_idx_t idx, logic [reb_pkg::CFG_BITS-1:0] val);
      case (idx)
        reb_pkg::REG_LOCKOUT:  lockout  = val[reb_pkg::LOCK_BITS-1:0];
        reb_pkg::REG_DEBOUNCE: debounce = val;
        reb_pkg::REG_LONG:     long_thr = val;
        default: ;
      endcase
    endfunction

    function logic [reb_pkg::TIMER_BITS-1:0] bump(logic [reb_pkg::TIMER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // position along the clockwise Gray cycle 00 -> 10 -> 11 -> 01
    function logic [1:0] turn_of(logic [1:0] from, logic [1:0] to);
      logic [1:0] p0, p1, d;
      p0 = {from[0], from[1] ^ from[0]};
      p1 = {to[0], to[1] ^ to[0]};
      d = p1 - p0;
      if (d == 2'd1) return reb_pkg::STEP_CW;
      if (d == 2'd3) return reb_pkg::STEP_CCW;
      return reb_pkg::STEP_NONE;
    endfunction

    function void note_sample(bit a, bit b, bit sw);
      knob_report_t r;
      bit was;
      r.step = reb_pkg::STEP_NONE;
      r.ev   = reb_pkg::EV_NONE;
      r.len  = '0;

      since_step = bump(since_step);
      if (since_step >= reb_pkg::TIMER_BITS'(lockout)) begin
        r.step = turn_of(prev_ab, {a, b});
        if (r.step == reb_pkg::STEP_CW) begin
          total = total + 1'b1;
          since_step = '0;
        end else if (r.step == reb_pkg::STEP_CCW) begin
          total = total - 1'b1;
          since_step = '0;
        end
        prev_ab = {a, b};
      end

      if (pressing) held_ticks = bump(held_ticks);
      if (sw != raw_sw) begin
        raw_sw = sw;
        stable_ticks = '0;
      end else begin
        stable_ticks = bump(stable_ticks);
      end
      if (stable_ticks >= debounce) begin
        was = deb_sw;
        deb_sw = sw;
        if (was && !sw) begin
          pressing = 1'b1;
          held_ticks = '0;
          ab_at_press = {a, b};
        end else if (!was && sw && pressing) begin
          pressing = 1'b0;
          r.len = held_ticks;
          if ({a, b} != ab_at_press) r.ev = reb_pkg::EV_GHOST;
          else if (held_ticks >= long_thr) r.ev = reb_pkg::EV_LONG;
          else r.ev = reb_pkg::EV_SHORT;
        end
      end
      r.total = total;
      due_reports.push_back(r);
    endfunction

    function void flag(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_report(logic [reb_pkg::OUT_BYTES_BITS-1:0] word);
      knob_report_t want;
      if (due_reports.size() == 0) begin
        flag($sformatf("report %h with nothing due", word));
        return;
      end
      want = due_reports.pop_front();
      if (word[1:0] != want.step)
        flag($sformatf("rotation_step exp %b got %b", want.step, word[1:0]));
      if (word[33:2] != want.total)
        flag($sformatf("step_total exp %0d got %0d", $signed(want.total),
                       $signed(word[33:2])));
      if (word[35:34] != want.ev)
        flag($sformatf("press_event exp %0d got %0d", want.ev, word[35:34]));
      if (word[59:36] != want.len)
        flag($sformatf("press_length exp %0d got %0d", want.len, word[59:36]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [reb_pkg::IN_BYTES_BITS-1:0] in_tdata;    // [0] line_a, [1] line_b, [2] switch_level
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [reb_pkg::OUT_BYTES_BITS-1:0] out_tdata;  // step, total, press_event, press_length
  logic cfg_wr_en;
  logic [reb_pkg::IDX_BITS-1:0] cfg_index;
  logic [reb_pkg::CFG_BITS-1:0] cfg_wdata;

  knob_scoreboard sb;
  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  logic [1:0] dial_pos;
  bit sw_lvl;
  logic [2:0] script [18];
  int n_phase;

  always #5 clk = ~clk;

  rotary_encoder_with_button u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (calm || stall_left == 0) begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 9) < 3)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end else begin
      out_tready <= 1'b0;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task send_sample(input bit a, input bit b, input bit sw);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, sw, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(a, b, sw);
  endtask

  task settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task write_reg(input reb_pkg::cfg_idx_t idx, input logic [reb_pkg::CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task configure(input int lock_v, input int deb_v, input int long_v);
    write_reg(reb_pkg::REG_LOCKOUT, reb_pkg::CFG_BITS'(lock_v));
    write_reg(reb_pkg::REG_DEBOUNCE, reb_pkg::CFG_BITS'(deb_v));
    write_reg(reb_pkg::REG_LONG, reb_pkg::CFG_BITS'(long_v));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // dial turned in runs with rests, button held and released, with bounce and noise
  task run_phase(input int n_items, input int lock_v, input int deb_v, input int long_v);
    int dial_hold, sw_hold;
    logic [1:0] dir;
    bit moving, a, b, sw_out;
    dial_hold = 0;
    sw_hold = $urandom_range(1, deb_v + 4);
    dir = 2'd1;
    moving = 1'b1;
    repeat (n_items) begin
      if (dial_hold == 0) begin
        if ($urandom_range(0, 9) == 0) moving = !moving;
        if ($urandom_range(0, 7) == 0) dir = -dir;
        if (moving) dial_pos = dial_pos + (($urandom_range(0, 19) == 0) ? 2'd2 : dir);
        dial_hold = $urandom_range(1, lock_v + 3);
      end
      dial_hold--;
      if (sw_hold == 0) begin
        sw_lvl = !sw_lvl;
        sw_hold = sw_lvl ? $urandom_range(deb_v + 1, deb_v + 10)
                         : $urandom_range(deb_v + 1, deb_v + long_v + 12);
      end
      sw_hold--;
      a = dial_pos[0] ^ dial_pos[1];
      b = dial_pos[1];
      sw_out = sw_lvl;
      if ($urandom_range(0, 24) == 0) sw_out = !sw_out;
      if ($urandom_range(0, 29) == 0) {a, b, sw_out} = 3'($urandom);
      send_sample(a, b, sw_out);
    end
  endtask

  initial begin
    // {line_a, line_b, switch_level}
    script = '{3'b011, 3'b001, 3'b101, 3'b111,   // clockwise turn
               3'b101, 3'b001,                   // counterclockwise
               3'b111,                           // jump across, no step
               3'b110, 3'b110, 3'b110, 3'b110, 3'b110,
               3'b111,                           // long press
               3'b110, 3'b111,                   // short press
               3'b110, 3'b010, 3'b011};          // dial moved: ghost
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = reb_pkg::REG_LOCKOUT;
    cfg_wdata = '0;
    sb = new;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: inside lockout, switch not yet stable
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1);
    settle();
    configure(0, 0, 4);
    foreach (script[i]) send_sample(script[i][2], script[i][1], script[i][0]);
    settle();

    dial_pos = 2'd3;
    sw_lvl = 1'b1;
    calm = 1'b0;
    configure(65535, 16777215, 16777215);
    run_phase(40, 65535, 16777215, 16777215);
    settle();
    calm = 1'b1;
    configure(0, 0, 0);
    run_phase(60, 0, 0, 0);
    settle();

    for (n_phase = 0; n_phase < 5; n_phase++) begin
      int lock_v, deb_v, long_v;
      lock_v = $urandom_range(0, 6);
      deb_v  = $urandom_range(0, 8);
      long_v = $urandom_range(0, 30);
      calm = ($urandom_range(0, 3) == 0);
      configure(lock_v, deb_v, long_v);
      run_phase(145, lock_v, deb_v, long_v);
      settle();
    end

    calm = 1'b0;
    repeat (4) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.due_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
